@@ design/lsfr_pkg.sv @@
// ----------------------------------------------------------------------------
// lsfr_pkg
// shared types and constants for the length/sum frame receiver
// ----------------------------------------------------------------------------
package lsfr_pkg;

   // frame header bytes
   localparam logic [7:0] HDR_FIRST  = 8'hAA;
   localparam logic [7:0] HDR_SECOND = 8'h55;

   // sum of both header bytes, seeds the running checksum
   localparam logic [31:0] SUM_HDR = 32'h0000_00FF;

   // length and checksum fields are four bytes each
   localparam int unsigned FIELD_BYTES = 4;
   localparam logic [15:0] FIELD_LAST  = 16'(FIELD_BYTES - 1);

   // smallest legal body length (checksum only)
   localparam logic [31:0] MIN_LEN = 32'(FIELD_BYTES);

   // reset value of the maximum body length register
   localparam logic [15:0] MAX_LEN_RESET = 16'd1024;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   // frame status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_SUM_ERR = 2'd1;
   localparam logic [1:0] STATUS_LEN_ERR = 2'd2;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      logic [15:0] index;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   // handshake between parser and the two register stages
   typedef struct packed {
      logic consume;
      logic res_valid;
   } ctrl_type;

endpackage

@@ design/lsfr_in_stage.sv @@
// ----------------------------------------------------------------------------
// lsfr_in_stage
// input word register, refilled in the cycle the parser consumes it
// ----------------------------------------------------------------------------
module lsfr_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       consume,
   output logic       byte_valid,
   output logic [7:0] byte_data
);
   logic       valid_ff;
   logic       valid_in;
   logic [7:0] data_ff;
   logic       load;

   assign req_ready = !valid_ff || consume;
   assign load      = req_valid && req_ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (consume) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_rx_byte;
      end
   end

   assign byte_valid = valid_ff;
   assign byte_data  = data_ff;
endmodule

@@ design/lsfr_parser.sv @@
// ----------------------------------------------------------------------------
// lsfr_parser
// frame state machine: header hunt, length, body, checksum
// ----------------------------------------------------------------------------
module lsfr_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              byte_valid,
   input  logic [7:0]        byte_data,
   input  logic              slot_free,
   input  logic [15:0]       max_len,
   output lsfr_pkg::ctrl_type ctrl,
   output lsfr_pkg::rsp_type  res_data
);
   import lsfr_pkg::*;

   typedef enum logic [2:0] {
      ST_HUNT1 = 3'd0,
      ST_HUNT2 = 3'd1,
      ST_LEN   = 3'd2,
      ST_BODY  = 3'd3,
      ST_CHECK = 3'd4
   } state_type;

   state_type   state_ff, state_in;
   logic [31:0] len_ff, len_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [31:0] sum_ff, sum_in;
   logic [31:0] chk_ff, chk_in;

   logic [31:0] len_full;
   logic [31:0] chk_full;
   logic [15:0] cnt_inc;
   logic [16:0] body_end;
   logic        len_bad;
   logic        produces;
   rsp_type     res;

   assign len_full = {len_ff[23:0], byte_data};
   assign chk_full = {chk_ff[23:0], byte_data};
   assign cnt_inc  = cnt_ff + 16'd1;
   assign body_end = {1'b0, cnt_inc} + 17'(FIELD_BYTES);
   assign len_bad  = (len_full < MIN_LEN) || (len_full > {16'd0, max_len});

   always_comb begin
      state_in = state_ff;
      len_in   = len_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      chk_in   = chk_ff;
      produces = 1'b0;
      res      = '0;
      unique case (state_ff)
         ST_HUNT1: begin
            state_in = (byte_data == HDR_FIRST) ? ST_HUNT2 : ST_HUNT1;
         end
         ST_HUNT2: begin
            if (byte_data == HDR_SECOND) begin
               sum_in   = SUM_HDR;
               state_in = ST_LEN;
               cnt_in   = '0;
               len_in   = '0;
            end else if (byte_data != HDR_FIRST) begin
               state_in = ST_HUNT1;
            end
         end
         ST_LEN: begin
            len_in = len_full;
            sum_in = sum_ff + {24'd0, byte_data};
            cnt_in = cnt_inc;
            if (cnt_ff == FIELD_LAST) begin
               cnt_in = '0;
               if (len_bad) begin
                  state_in   = ST_HUNT1;
                  len_in     = '0;
                  sum_in     = '0;
                  chk_in     = '0;
                  produces   = 1'b1;
                  res.kind   = KIND_STATUS;
                  res.status = STATUS_LEN_ERR;
                  res.last   = 1'b1;
               end else begin
                  chk_in   = '0;
                  state_in = (len_full == MIN_LEN) ? ST_CHECK : ST_BODY;
               end
            end
         end
         ST_BODY: begin
            sum_in = sum_ff + {24'd0, byte_data};
            cnt_in = cnt_inc;
            // length is at most 16 bits once the body is entered
            if (body_end >= {1'b0, len_ff[15:0]}) begin
               state_in = ST_CHECK;
               cnt_in   = '0;
               chk_in   = '0;
            end
            produces  = 1'b1;
            res.kind  = KIND_PAYLOAD;
            res.data  = byte_data;
            res.index = cnt_ff;
         end
         ST_CHECK: begin
            chk_in = chk_full;
            cnt_in = cnt_inc;
            if (cnt_ff == FIELD_LAST) begin
               state_in   = ST_HUNT1;
               len_in     = '0;
               cnt_in     = '0;
               sum_in     = '0;
               chk_in     = '0;
               produces   = 1'b1;
               res.kind   = KIND_STATUS;
               res.status = (chk_full == sum_ff) ? STATUS_OK : STATUS_SUM_ERR;
               res.last   = 1'b1;
            end
         end
         default: begin
            // unused codes behave as hunting
            state_in = (byte_data == HDR_FIRST) ? ST_HUNT2 : ST_HUNT1;
         end
      endcase
   end

   assign ctrl.consume   = byte_valid && (!produces || slot_free);
   assign ctrl.res_valid = ctrl.consume && produces;
   assign res_data       = res;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT1;
         len_ff   <= '0;
         cnt_ff   <= '0;
         sum_ff   <= '0;
         chk_ff   <= '0;
      end else if (ctrl.consume) begin
         state_ff <= state_in;
         len_ff   <= len_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         chk_ff   <= chk_in;
      end
   end
endmodule

@@ design/lsfr_out_stage.sv @@
// ----------------------------------------------------------------------------
// lsfr_out_stage
// result register toward the response channel
// ----------------------------------------------------------------------------
module lsfr_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  lsfr_pkg::ctrl_type ctrl,
   input  lsfr_pkg::rsp_type  res_data,
   output logic              slot_free,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lsfr_pkg::rsp_type  rsp_data
);
   import lsfr_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign slot_free = !valid_ff || rsp_ready;

   always_comb begin
      if (ctrl.res_valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.res_valid) begin
         data_ff <= res_data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;
endmodule

@@ design/length_sum_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// length_sum_frame_receiver
// byte-stream receiver for length-prefixed frames with an additive checksum
// ----------------------------------------------------------------------------
// One received byte is taken per word on the req channel, and a new word can
// be taken in every cycle unless rsp_ready holds a result back: the
// sustained rate is one byte per clock, set by the frame state machine.
// A byte waits in the input word register, its result word in the result
// register. The block hunts for the header 0xAA 0x55, reads a 4-byte
// big-endian body length, then passes body bytes out as payload words with
// their index until the last 4 body bytes, which hold the big-endian 32-bit
// wrapping sum of all frame bytes before them. The last checksum byte yields
// one status word (ok or checksum error). A length below 4 or above
// max_body_length yields a bad-length status word at once and a return to
// hunting. The user writes max_body_length through csr_wr_en and
// csr_wr_data, only while the block is idle; the block does not enforce it.
// req_ready depends on rsp_ready within the same cycle.
// ----------------------------------------------------------------------------
module length_sum_frame_receiver (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // received byte words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   // result words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_out_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_payload_index,
   output logic [1:0]  rsp_frame_status,
   output logic        rsp_frame_last
);
   import lsfr_pkg::*;

   // maximum body length register
   logic [15:0] max_len_ff;

   // between the stages
   logic     byte_valid;
   logic [7:0] byte_data;
   logic     slot_free;
   ctrl_type ctrl;
   rsp_type  res_data;
   rsp_type  rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   // input word register
   lsfr_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .consume     (ctrl.consume),
      .byte_valid  (byte_valid),
      .byte_data   (byte_data)
   );

   // frame state machine, one byte per consume
   lsfr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (byte_valid),
      .byte_data  (byte_data),
      .slot_free  (slot_free),
      .max_len    (max_len_ff),
      .ctrl       (ctrl),
      .res_data   (res_data)
   );

   // result register
   lsfr_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .res_data  (res_data),
      .slot_free (slot_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_out_kind      = rsp_data.kind;
   assign rsp_payload_byte  = rsp_data.data;
   assign rsp_payload_index = rsp_data.index;
   assign rsp_frame_status  = rsp_data.status;
   assign rsp_frame_last    = rsp_data.last;

   // no response word right after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response word valid after reset");

   // a new result never overwrites a word still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.res_valid |-> (!rsp_valid || rsp_ready))
      else $error("result loaded over a pending response word");

   // a byte held in the input register is not dropped while stalled
   a_byte_held: assert property (@(posedge clock) disable iff (reset)
      (byte_valid && !ctrl.consume) |=> byte_valid)
      else $error("input byte lost while stalled");

   // payload words carry ok status and are never frame end
   a_payload_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_kind == KIND_PAYLOAD) |->
      (rsp_frame_status == STATUS_OK && !rsp_frame_last))
      else $error("payload word with status fields set");
endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the length/sum frame receiver
// ----------------------------------------------------------------------------
// A short table of directed bytes comes first. It covers header resync, a
// broken header, a frame with no payload, a short length and a long length.
// Random frames follow under several max_body_length settings, the extremes
// among them. A bit-exact frame parser in the bench predicts every result
// word that the table does not type in. Both sides idle in random bursts,
// and the last setting runs at full rate.
// ----------------------------------------------------------------------------
module tb;
   import lsfr_pkg::*;

   localparam int unsigned STALL_LIMIT       = 2000;
   localparam int unsigned DRAIN_CYCLES      = 4;
   localparam int unsigned WORDS_PER_SETTING = 80;
   localparam int unsigned NUM_SETTINGS      = 6;
   localparam int unsigned NUM_ROWS          = 25;

   // parser phases, same order as the block's frame state machine
   typedef enum logic [2:0] {
      HUNT_FIRST  = 3'd0,
      HUNT_SECOND = 3'd1,
      READ_LEN    = 3'd2,
      READ_BODY   = 3'd3,
      READ_SUM    = 3'd4
   } rx_phase_type;

   // one directed byte, with a result word typed in where it is obvious
   typedef struct packed {
      logic [7:0] data;
      logic       pin;
      rsp_type    rsp;
   } stim_row_type;

   localparam rsp_type NO_WORD = '0;
   localparam rsp_type FRAME_OK = '{kind: KIND_STATUS, data: 8'h00, index: 16'h0000,
                                    status: STATUS_OK, last: 1'b1};
   localparam rsp_type FRAME_BAD_LEN = '{kind: KIND_STATUS, data: 8'h00, index: 16'h0000,
                                         status: STATUS_LEN_ERR, last: 1'b1};

   localparam stim_row_type DIRECTED_ROWS [0:NUM_ROWS-1] = '{
      // header broken off, back to hunting
      '{HDR_FIRST,  1'b0, NO_WORD},
      '{8'h00,      1'b0, NO_WORD},
      // repeated first header byte keeps the hunt alive
      '{HDR_FIRST,  1'b0, NO_WORD},
      '{HDR_FIRST,  1'b0, NO_WORD},
      '{HDR_SECOND, 1'b0, NO_WORD},
      // length 4: no payload, checksum at once
      '{8'h00,      1'b0, NO_WORD},
      '{8'h00,      1'b0, NO_WORD},
      '{8'h00,      1'b0, NO_WORD},
      '{8'h04,      1'b0, NO_WORD},
      // checksum 0xaa + 0x55 + 0x04
      '{8'h00,      1'b0, NO_WORD},
      '{8'h00,      1'b0, NO_WORD},
      '{8'h01,      1'b0, NO_WORD},
      '{8'h03,      1'b1, FRAME_OK},
      // short length
      '{HDR_FIRST,  1'b0, NO_WORD},
      '{HDR_SECOND, 1'b0, NO_WORD},
      '{8'h00,      1'b0, NO_WORD},
      '{8'h00,      1'b0, NO_WORD},
      '{8'h00,      1'b0, NO_WORD},
      '{8'h03,      1'b1, FRAME_BAD_LEN},
      // all-ones length, far above the limit
      '{HDR_FIRST,  1'b0, NO_WORD},
      '{HDR_SECOND, 1'b0, NO_WORD},
      '{8'hFF,      1'b0, NO_WORD},
      '{8'hFF,      1'b0, NO_WORD},
      '{8'hFF,      1'b0, NO_WORD},
      '{8'hFF,      1'b1, FRAME_BAD_LEN}
   };

   // block ports, every input known from time zero
   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        csr_wr_en   = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_valid   = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = '0;
   logic        rsp_valid;
   logic        rsp_ready   = 1'b1;
   logic        rsp_out_kind;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_payload_index;
   logic [1:0]  rsp_frame_status;
   logic        rsp_frame_last;

   // typed-in result that travels with the current req word
   logic        req_pin      = 1'b0;
   rsp_type     req_pin_word = '0;

   // idling switches, changed between settings
   bit          gap_on   = 1'b0;
   bit          stall_on = 1'b0;

   // parser copy: phase, length and checksum registers, current limit
   rx_phase_type rx_phase;
   logic [31:0]  len_shift;
   logic [15:0]  phase_count;
   logic [31:0]  frame_sum;
   logic [31:0]  sum_shift;
   logic [15:0]  len_limit;

   rsp_type     expected_words [$];
   rsp_type     got_word;
   rsp_type     want_word;
   rsp_type     next_word;
   bit          has_word;
   int unsigned frame_words;
   int unsigned quiet_cycles  = 0;
   int unsigned mismatch_count = 0;

   length_sum_frame_receiver i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_kind      (rsp_out_kind),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_payload_index (rsp_payload_index),
      .rsp_frame_status  (rsp_frame_status),
      .rsp_frame_last    (rsp_frame_last)
   );

   assign got_word = {rsp_out_kind, rsp_payload_byte, rsp_payload_index,
                      rsp_frame_status, rsp_frame_last};

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // frame parser
   // ------------------------------------------------------------------------

   // back to hunting, all frame registers cleared
   function automatic void restart_hunt();
      rx_phase    = HUNT_FIRST;
      len_shift   = '0;
      phase_count = '0;
      frame_sum   = '0;
      sum_shift   = '0;
   endfunction

   // advance the parser by one byte, returns 1 when a result word is due
   function automatic bit frame_predict(input logic [7:0] b, output rsp_type word);
      logic [15:0] idx;
      word = NO_WORD;
      case (rx_phase)
         HUNT_SECOND: begin
            if (b == HDR_SECOND) begin
               frame_sum   = SUM_HDR;
               rx_phase    = READ_LEN;
               phase_count = '0;
               len_shift   = '0;
            end else if (b != HDR_FIRST) begin
               rx_phase = HUNT_FIRST;
            end
            return 1'b0;
         end
         READ_LEN: begin
            len_shift   = {len_shift[23:0], b};
            frame_sum   = frame_sum + 32'(b);
            phase_count = phase_count + 16'd1;
            if (phase_count < 16'(FIELD_BYTES))
               return 1'b0;
            phase_count = '0;
            // short or long length, rejected at once
            if (len_shift < MIN_LEN || len_shift > 32'(len_limit)) begin
               restart_hunt();
               word = FRAME_BAD_LEN;
               return 1'b1;
            end
            sum_shift = '0;
            rx_phase  = (len_shift == MIN_LEN) ? READ_SUM : READ_BODY;
            return 1'b0;
         end
         READ_BODY: begin
            idx         = phase_count;
            frame_sum   = frame_sum + 32'(b);
            phase_count = phase_count + 16'd1;
            // last four body bytes carry the checksum
            if (32'(phase_count) + MIN_LEN >= len_shift) begin
               rx_phase    = READ_SUM;
               phase_count = '0;
               sum_shift   = '0;
            end
            word = '{kind: KIND_PAYLOAD, data: b, index: idx, status: STATUS_OK, last: 1'b0};
            return 1'b1;
         end
         READ_SUM: begin
            sum_shift   = {sum_shift[23:0], b};
            phase_count = phase_count + 16'd1;
            if (phase_count < 16'(FIELD_BYTES))
               return 1'b0;
            word = FRAME_OK;
            if (sum_shift != frame_sum)
               word.status = STATUS_SUM_ERR;
            restart_hunt();
            return 1'b1;
         end
         default: begin
            rx_phase = (b == HDR_FIRST) ? HUNT_SECOND : HUNT_FIRST;
            return 1'b0;
         end
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch in %s: got %0h, want %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   // results first: a word taken at this edge cannot stem from a byte taken at it
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               report_mismatch("word with nothing pending", 32'(got_word), 32'h0);
            end else begin
               want_word = expected_words.pop_front();
               if (got_word.kind != want_word.kind)
                  report_mismatch("out_kind", 32'(got_word.kind), 32'(want_word.kind));
               if (got_word.data != want_word.data)
                  report_mismatch("payload_byte", 32'(got_word.data), 32'(want_word.data));
               if (got_word.index != want_word.index)
                  report_mismatch("payload_index", 32'(got_word.index), 32'(want_word.index));
               if (got_word.status != want_word.status)
                  report_mismatch("frame_status", 32'(got_word.status), 32'(want_word.status));
               if (got_word.last != want_word.last)
                  report_mismatch("frame_last", 32'(got_word.last), 32'(want_word.last));
            end
         end
         // every accepted byte steps the parser, typed-in rows override its word
         if (req_valid && req_ready) begin
            has_word = frame_predict(req_rx_byte, next_word);
            if (req_pin)
               expected_words.push_back(req_pin_word);
            else if (has_word)
               expected_words.push_back(next_word);
         end
      end
   end

   // watchdog: too long without any word moving on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == STALL_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // result side: random stall bursts while stall_on is set
   // ------------------------------------------------------------------------
   initial begin
      forever begin
         @(negedge clock);
         if (stall_on && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end
         rsp_ready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------------
   // byte side
   // ------------------------------------------------------------------------

   // one byte word, with an optional gap burst ahead of it; ends on a falling edge
   task automatic send_word(input logic [7:0] b, input logic pin, input rsp_type pin_word);
      if (gap_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_valid    <= 1'b1;
      req_rx_byte  <= b;
      req_pin      <= pin;
      req_pin_word <= pin_word;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // drop valid and let every pending word and the pipeline drain
   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // limit register, written only with the block drained
   task automatic write_max_len(input logic [15:0] value);
      drain_block();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      len_limit = value;
   endtask

   // mostly well-formed frames with random content, some noise and bad frames
   task automatic send_frame(input logic [15:0] limit);
      logic [31:0] body_len;
      logic [31:0] sum;
      logic [31:0] check;
      logic [7:0]  b;
      int unsigned roll;
      int unsigned top;
      roll = $urandom_range(0, 99);
      // line noise ahead of the header
      if (roll < 8) begin
         repeat ($urandom_range(1, 3)) send_word(8'($urandom_range(0, 255)), 1'b0, NO_WORD);
      end
      // header broken off after the first byte
      if (roll >= 8 && roll < 14) begin
         send_word(HDR_FIRST, 1'b0, NO_WORD);
         send_word(8'($urandom_range(0, 255)), 1'b0, NO_WORD);
         frame_words += 2;
         return;
      end
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
         body_len = $urandom_range(0, 3);
      end else if (roll < 16) begin
         // just over the limit, or anywhere in 32 bits
         body_len = (roll < 12) ? 32'(limit) + 32'd1 : 32'($urandom);
         if (body_len <= 32'(limit))
            body_len = 32'(limit) + 32'd1;
      end else begin
         // mostly small bodies, a few long ones
         top = (roll < 96) ? 40 : 600;
         if (32'(limit) < MIN_LEN)
            body_len = $urandom_range(4, top);
         else
            body_len = $urandom_range(4, (32'(limit) < top) ? 32'(limit) : top);
      end
      sum = SUM_HDR;
      send_word(HDR_FIRST, 1'b0, NO_WORD);
      send_word(HDR_SECOND, 1'b0, NO_WORD);
      for (int i = 3; i >= 0; i--) begin
         b = body_len[8*i +: 8];
         sum = sum + 32'(b);
         send_word(b, 1'b0, NO_WORD);
      end
      frame_words += 6;
      // rejected length, block is hunting again
      if (body_len < MIN_LEN || body_len > 32'(limit))
         return;
      for (int unsigned i = 4; i < body_len; i++) begin
         b = 8'($urandom_range(0, 255));
         sum = sum + 32'(b);
         send_word(b, 1'b0, NO_WORD);
         frame_words++;
      end
      // one frame in ten with a corrupted checksum
      check = sum;
      if ($urandom_range(0, 9) == 0)
         check = check ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 3; i >= 0; i--)
         send_word(check[8*i +: 8], 1'b0, NO_WORD);
      frame_words += 4;
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin : main_seq
      logic [15:0] settings [0:NUM_SETTINGS-1];
      bit          is_last;
      restart_hunt();
      len_limit = MAX_LEN_RESET;
      // reset held from time zero, released on a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table under the reset limit
      gap_on   = 1'b1;
      stall_on = 1'b1;
      for (int i = 0; i < NUM_ROWS; i++)
         send_word(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].pin, DIRECTED_ROWS[i].rsp);

      // small, smallest legal, largest, random, below legal, back to reset value
      settings[0] = 16'd16;
      settings[1] = 16'(MIN_LEN);
      settings[2] = 16'hFFFF;
      settings[3] = 16'($urandom_range(5, 300));
      settings[4] = 16'd0;
      settings[5] = MAX_LEN_RESET;

      for (int p = 0; p < NUM_SETTINGS; p++) begin
         write_max_len(settings[p]);
         is_last  = (p == NUM_SETTINGS - 1);
         // stretches without gaps or without stalls, none at all at the end
         gap_on   = !is_last && (p % 3 != 1);
         stall_on = !is_last && (p % 3 != 2);
         frame_words = 0;
         while (frame_words < WORDS_PER_SETTING)
            send_frame(settings[p]);
      end

      drain_block();
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ sim.f @@
design/lsfr_pkg.sv
design/lsfr_in_stage.sv
design/lsfr_parser.sv
design/lsfr_out_stage.sv
design/length_sum_frame_receiver.sv
sim/tb.sv
